>>> src/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg - shared types for the periodic timer table
// Command and status codes, transaction structs and the stored entry layout.
// ----------------------------------------------------------------------------
package ptt_pkg;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_TICK_END,
    S_SCAN,
    S_SHIFT
  } state_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] timer_id;
    logic [31:0] period;
  } req_t;

  typedef struct packed {
    logic        fired;
    logic [15:0] fired_id;
    status_t     status;
    logic [63:0] tick_count;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] period;
    logic [31:0] elapsed;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

>>> src/ptt_ram.sv
// ----------------------------------------------------------------------------
// ptt_ram - timer entry store
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module ptt_ram #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6,
  parameter int WIDTH  = 80
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> src/periodic_timer_table.sv
// ----------------------------------------------------------------------------
// periodic_timer_table - table of periodic timers
// Adds, removes and ticks up to TIMER_SLOTS timers held in one entry RAM.
// ----------------------------------------------------------------------------
//
//   channel   | handshake              | payload
//   ----------+------------------------+--------------------------------------
//   command   | start, busy            | req (cmd, timer_id, period)
//   result    | valid (one-cycle pulse)| rsp (fired, fired_id, status,
//             |                        |      tick_count, last)
//
// Add, the unused command code, and a tick or remove on an empty table give
// their single result in the cycle after the transaction and never raise busy.
// A tick over n entries does one RAM read-modify-write per entry through the
// single read port in S_TICK, then gives the final result from S_TICK_END.
// A remove searches with up to n reads in S_SCAN, then in S_SHIFT does one
// read and one write per entry that moves down to close the gap.
// Reset clears the entry count, the tick counter and the sequencer; the RAM
// needs no clearing pass, since only slots below the entry count are read.
// The receiver cannot stall: each result shows on rsp for one cycle with valid.
//
// Storage order: physical slot 0 holds the oldest entry and slot count-1 the
// newest, so an add appends without moving anything, and walks run from the
// top slot downwards to visit entries newest first.
// ----------------------------------------------------------------------------
module periodic_timer_table
  import ptt_pkg::*;
#(
  parameter int TIMER_SLOTS = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic valid,
  output rsp_t rsp
);

  localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CNT_W  = $clog2(TIMER_SLOTS + 1);
  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(TIMER_SLOTS);

  // Sequencer and datapath registers
  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [63:0]       ticks, ticks_next;
  logic [SLOT_W-1:0] rd_addr, rd_addr_next;   // slot whose entry is now on the RAM read data
  logic [15:0]       req_id, req_id_next;     // identifier held for a remove
  logic              pend_valid, pend_valid_next;
  logic [15:0]       pend_id, pend_id_next;   // fired entry held back for its last flag
  logic              valid_next;
  rsp_t              rsp_next;

  // RAM port signals
  logic              we;
  logic [SLOT_W-1:0] waddr, raddr;
  entry_t            wdata, rdata;
  logic [ENTRY_W-1:0] rdata_raw;

  // Tick update of the entry just read
  logic [31:0]       elapsed_inc;
  logic              fire;
  logic [SLOT_W-1:0] last_idx;

  ptt_ram #(
    .DEPTH (TIMER_SLOTS),
    .ADDR_W(SLOT_W),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata_raw)
  );

  assign rdata       = entry_t'(rdata_raw);
  assign busy        = (state != S_IDLE);
  assign last_idx    = SLOT_W'(count - CNT_W'(1));
  assign elapsed_inc = rdata.elapsed + 32'd1;
  assign fire        = (elapsed_inc >= rdata.period);

  function automatic rsp_t make_rsp(logic f, logic [15:0] id, status_t st,
                                    logic [63:0] tc, logic lst);
    rsp_t r;
    r.fired      = f;
    r.fired_id   = id;
    r.status     = st;
    r.tick_count = tc;
    r.last       = lst;
    return r;
  endfunction

  always_comb begin
    state_next      = state;
    count_next      = count;
    ticks_next      = ticks;
    rd_addr_next    = rd_addr;
    req_id_next     = req_id;
    pend_valid_next = pend_valid;
    pend_id_next    = pend_id;
    valid_next      = 1'b0;
    rsp_next        = rsp;
    we              = 1'b0;
    waddr           = rd_addr;
    wdata           = rdata;
    raddr           = rd_addr;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          req_id_next = req.timer_id;
          unique case (req.cmd)
            CMD_TICK: begin
              ticks_next = ticks + 64'd1;
              if (count == '0) begin
                // Nothing stored: report an empty tick straight away
                valid_next = 1'b1;
                rsp_next   = make_rsp(1'b0, 16'd0, ST_OK, ticks + 64'd1, 1'b1);
              end else begin
                // Start the walk at the newest entry
                raddr           = last_idx;
                rd_addr_next    = last_idx;
                pend_valid_next = 1'b0;
                state_next      = S_TICK;
              end
            end
            CMD_ADD: begin
              valid_next = 1'b1;
              if (count >= SLOTS_C) begin
                rsp_next = make_rsp(1'b0, 16'd0, ST_FULL, ticks, 1'b1);
              end else begin
                // Append as the newest entry with its elapsed count cleared
                we            = 1'b1;
                waddr         = SLOT_W'(count);
                wdata.id      = req.timer_id;
                wdata.period  = req.period;
                wdata.elapsed = 32'd0;
                count_next    = count + CNT_W'(1);
                rsp_next      = make_rsp(1'b0, 16'd0, ST_OK, ticks, 1'b1);
              end
            end
            CMD_REMOVE: begin
              if (count == '0) begin
                valid_next = 1'b1;
                rsp_next   = make_rsp(1'b0, 16'd0, ST_NOTFOUND, ticks, 1'b1);
              end else begin
                raddr        = last_idx;
                rd_addr_next = last_idx;
                state_next   = S_SCAN;
              end
            end
            default: begin
              // Unused code: acknowledge and change nothing
              valid_next = 1'b1;
              rsp_next   = make_rsp(1'b0, 16'd0, ST_OK, ticks, 1'b1);
            end
          endcase
        end
      end

      S_TICK: begin
        // Write back the advanced count, cleared when the entry fires
        we            = 1'b1;
        waddr         = rd_addr;
        wdata         = rdata;
        wdata.elapsed = fire ? 32'd0 : elapsed_inc;
        if (fire) begin
          // Release the previously held firing; it is not the final one
          if (pend_valid) begin
            valid_next = 1'b1;
            rsp_next   = make_rsp(1'b1, pend_id, ST_OK, ticks, 1'b0);
          end
          pend_valid_next = 1'b1;
          pend_id_next    = rdata.id;
        end
        if (rd_addr == '0) begin
          state_next = S_TICK_END;
        end else begin
          raddr        = rd_addr - SLOT_W'(1);
          rd_addr_next = rd_addr - SLOT_W'(1);
        end
      end

      S_TICK_END: begin
        valid_next = 1'b1;
        if (pend_valid) begin
          rsp_next = make_rsp(1'b1, pend_id, ST_OK, ticks, 1'b1);
        end else begin
          rsp_next = make_rsp(1'b0, 16'd0, ST_OK, ticks, 1'b1);
        end
        pend_valid_next = 1'b0;
        state_next      = S_IDLE;
      end

      S_SCAN: begin
        if (rdata.id == req_id) begin
          if (rd_addr == last_idx) begin
            // Newest entry matched: drop it, nothing to move
            count_next = count - CNT_W'(1);
            valid_next = 1'b1;
            rsp_next   = make_rsp(1'b0, 16'd0, ST_OK, ticks, 1'b1);
            state_next = S_IDLE;
          end else begin
            raddr        = rd_addr + SLOT_W'(1);
            rd_addr_next = rd_addr + SLOT_W'(1);
            state_next   = S_SHIFT;
          end
        end else if (rd_addr == '0) begin
          valid_next = 1'b1;
          rsp_next   = make_rsp(1'b0, 16'd0, ST_NOTFOUND, ticks, 1'b1);
          state_next = S_IDLE;
        end else begin
          raddr        = rd_addr - SLOT_W'(1);
          rd_addr_next = rd_addr - SLOT_W'(1);
        end
      end

      S_SHIFT: begin
        // Move each newer entry down one slot to close the gap
        we    = 1'b1;
        waddr = rd_addr - SLOT_W'(1);
        wdata = rdata;
        if (rd_addr == last_idx) begin
          count_next = count - CNT_W'(1);
          valid_next = 1'b1;
          rsp_next   = make_rsp(1'b0, 16'd0, ST_OK, ticks, 1'b1);
          state_next = S_IDLE;
        end else begin
          raddr        = rd_addr + SLOT_W'(1);
          rd_addr_next = rd_addr + SLOT_W'(1);
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      ticks      <= 64'd0;
      pend_valid <= 1'b0;
      valid      <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      ticks      <= ticks_next;
      pend_valid <= pend_valid_next;
      valid      <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr <= rd_addr_next;
    req_id  <= req_id_next;
    pend_id <= pend_id_next;
    rsp     <= rsp_next;
  end

endmodule

>>> tb/tb_periodic_timer_table.sv
// ----------------------------------------------------------------------------
// tb_periodic_timer_table - self-checking bench for the periodic timer table
// Drives add, remove, tick and unused-code commands through the start/busy
// port. A shadow copy of the table predicts every result. A checker compares
// each result strobe with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb_periodic_timer_table;
  import ptt_pkg::*;

  localparam int          SLOTS      = 64;
  // Command code three is not in cmd_t. The block must ignore it and still
  // answer with one plain result.
  localparam logic [1:0]  CMD_UNUSED = 2'd3;
  // Longest tick walks every slot and then emits the final result.
  localparam int          DRAIN_WAIT = SLOTS + 16;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t req;
  logic valid;
  rsp_t rsp;

  // Shadow of the table. Index 0 holds the newest entry, as the block
  // reports it.
  entry_t      shadow_timers[$];
  logic [63:0] shadow_ticks;
  // Results still owed by the block, oldest first.
  rsp_t        due_results[$];

  int errors;
  int burst_left;
  bit gaps_on;

  periodic_timer_table #(
    .TIMER_SLOTS(SLOTS)
  ) u_top (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .valid(valid),
    .rsp  (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Guard against a hung block: abandon the run after a generous time.
  initial begin
    #500000;
    $display("CHECKS FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic rsp_t make_result(logic fired, logic [15:0] id, status_t st,
                                       logic last);
    rsp_t r;
    r            = '0;
    r.fired      = fired;
    r.fired_id   = id;
    r.status     = st;
    r.tick_count = shadow_ticks;
    r.last       = last;
    return r;
  endfunction

  // Apply one accepted transaction to the shadow table and queue the results
  // that it must cause.
  task automatic predict_timer_results(input req_t item);
    entry_t ent;
    rsp_t   tail;
    int     hits;
    int     pos;
    status_t st;
    st = ST_OK;
    case (item.cmd)
      CMD_TICK: begin
        shadow_ticks = shadow_ticks + 64'd1;
        hits = 0;
        // Walk newest to oldest; an entry that reaches its period fires and
        // restarts from zero.
        foreach (shadow_timers[i]) begin
          ent = shadow_timers[i];
          ent.elapsed = ent.elapsed + 32'd1;
          if (ent.elapsed >= ent.period) begin
            due_results.push_back(make_result(1'b1, ent.id, ST_OK, 1'b0));
            ent.elapsed = '0;
            hits++;
          end
          shadow_timers[i] = ent;
        end
        if (hits == 0) begin
          due_results.push_back(make_result(1'b0, 16'd0, ST_OK, 1'b1));
        end else begin
          // Mark the final expiry of this tick.
          tail = due_results.pop_back();
          tail.last = 1'b1;
          due_results.push_back(tail);
        end
      end
      CMD_ADD: begin
        if (shadow_timers.size() >= SLOTS) begin
          st = ST_FULL;
        end else begin
          ent.id      = item.timer_id;
          ent.period  = item.period;
          ent.elapsed = '0;
          shadow_timers.push_front(ent);
        end
        due_results.push_back(make_result(1'b0, 16'd0, st, 1'b1));
      end
      CMD_REMOVE: begin
        // Take the newest entry with this identifier.
        pos = -1;
        foreach (shadow_timers[i]) begin
          if (pos < 0 && shadow_timers[i].id == item.timer_id) pos = i;
        end
        if (pos < 0) begin
          st = ST_NOTFOUND;
        end else begin
          shadow_timers.delete(pos);
        end
        due_results.push_back(make_result(1'b0, 16'd0, st, 1'b1));
      end
      default: begin
        due_results.push_back(make_result(1'b0, 16'd0, ST_OK, 1'b1));
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Result checking: each strobe consumes the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    rsp_t want;
    if (!rst && valid) begin
      if (due_results.size() == 0) begin
        $error("result with nothing pending: fired %0b fired_id %h status %0d",
               rsp.fired, rsp.fired_id, rsp.status);
        errors++;
      end else begin
        want = due_results.pop_front();
        if (rsp.fired !== want.fired) begin
          $error("fired: expected %0b actual %0b", want.fired, rsp.fired);
          errors++;
        end
        if (rsp.fired_id !== want.fired_id) begin
          $error("fired_id: expected %h actual %h", want.fired_id, rsp.fired_id);
          errors++;
        end
        if (rsp.status !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, rsp.status);
          errors++;
        end
        if (rsp.tick_count !== want.tick_count) begin
          $error("tick_count: expected %0d actual %0d", want.tick_count,
                 rsp.tick_count);
          errors++;
        end
        if (rsp.last !== want.last) begin
          $error("last: expected %0b actual %0b", want.last, rsp.last);
          errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------
  function automatic req_t make_req(cmd_t cmd, logic [15:0] id, logic [31:0] per);
    req_t r;
    r.cmd      = cmd;
    r.timer_id = id;
    r.period   = per;
    return r;
  endfunction

  // Drop start and scramble the payload meanwhile so that the block is seen to
  // ignore it.
  task automatic hold_off(input int n);
    @(negedge clk);
    start <= 1'b0;
    req   <= make_req(cmd_t'(2'($urandom)), 16'($urandom), $urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  // Offer one transaction and hold it until the block takes it. Start stays
  // high on return so that a burst runs back to back.
  task automatic send_item(input req_t item);
    if (gaps_on && burst_left <= 0) begin
      hold_off($urandom_range(1, 6));
      burst_left = $urandom_range(1, 10);
    end
    @(negedge clk);
    start <= 1'b1;
    req   <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_timer_results(item);
    burst_left--;
  endtask

  // Pause the sender until every owed result has come back.
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  // Mostly a small pool so that duplicates and hits on remove are common.
  function automatic logic [15:0] pick_id();
    if ($urandom_range(0, 9) < 7) begin
      return ($urandom_range(0, 8) == 8) ? 16'hFFFF : 16'($urandom_range(0, 7));
    end
    return 16'($urandom);
  endfunction

  // Mostly short periods so that timers fire often; some full-range ones.
  function automatic logic [31:0] pick_period();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 32'($urandom_range(0, 6));
    if (sel < 85) return 32'($urandom_range(7, 40));
    return $urandom;
  endfunction

  // Identifier of a stored timer where there is one, else any identifier.
  function automatic logic [15:0] stored_id();
    if (shadow_timers.size() == 0) return 16'($urandom);
    return shadow_timers[$urandom_range(0, shadow_timers.size() - 1)].id;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Field extremes, duplicates, period zero and one, absent identifiers,
  // empty-table tick and remove, and the unused command code.
  task automatic test_directed();
    gaps_on = 1'b0;
    send_item(make_req(CMD_TICK, 16'h0000, 32'h0));
    send_item(make_req(CMD_REMOVE, 16'h0000, 32'h0));
    send_item(make_req(CMD_ADD, 16'h0000, 32'h0000_0000));
    send_item(make_req(CMD_ADD, 16'hFFFF, 32'hFFFF_FFFF));
    send_item(make_req(CMD_ADD, 16'h8000, 32'h0000_0001));
    send_item(make_req(CMD_ADD, 16'h0000, 32'h0000_0003));
    repeat (3) send_item(make_req(CMD_TICK, 16'hFFFF, 32'hFFFF_FFFF));
    send_item(make_req(CMD_REMOVE, 16'h0000, 32'h0));
    send_item(make_req(CMD_TICK, 16'h0000, 32'h0));
    send_item(make_req(CMD_REMOVE, 16'h1234, 32'hFFFF_FFFF));
    send_item(make_req(cmd_t'(CMD_UNUSED), 16'hFFFF, 32'hFFFF_FFFF));
    send_item(make_req(CMD_REMOVE, 16'hFFFF, 32'h0));
    send_item(make_req(CMD_REMOVE, 16'h0000, 32'h0));
    send_item(make_req(CMD_REMOVE, 16'h8000, 32'h0));
    send_item(make_req(CMD_TICK, 16'h0000, 32'h0));
    send_item(make_req(CMD_ADD, 16'h5555, 32'h0000_0002));
    send_item(make_req(CMD_ADD, 16'hAAAA, 32'hAAAA_AAAA));
    send_item(make_req(CMD_ADD, 16'h5555, 32'h5555_5555));
    repeat (2) send_item(make_req(CMD_TICK, 16'h0000, 32'h0));
    send_item(make_req(cmd_t'(CMD_UNUSED), 16'h0000, 32'h0));
  endtask

  // Fill the table, hit the full limit, tick a full table, then thin it out.
  task automatic test_table_full();
    gaps_on = 1'b1;
    while (shadow_timers.size() < SLOTS) begin
      send_item(make_req(CMD_ADD, pick_id(), 32'($urandom_range(0, 3))));
    end
    repeat (2) send_item(make_req(CMD_ADD, 16'($urandom), $urandom));
    repeat (4) send_item(make_req(CMD_TICK, 16'($urandom), $urandom));
    repeat (SLOTS / 2) send_item(make_req(CMD_REMOVE, stored_id(), $urandom));
    send_item(make_req(CMD_REMOVE, 16'hFFFE, 32'h0));
  endtask

  // Mixed traffic with random content; alternate stretches with and without
  // sender gaps, and drain completely every so often.
  task automatic test_random_traffic(input int n);
    int   sel;
    req_t item;
    for (int i = 0; i < n; i++) begin
      if (i % 30 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      if (i % 45 == 44) wait_drained();
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        item = make_req(CMD_TICK, 16'($urandom), $urandom);
      end else if (sel < 70) begin
        item = make_req(CMD_ADD, pick_id(), pick_period());
      end else if (sel < 95) begin
        // Mostly stored identifiers; the rest are usually absent.
        item = make_req(CMD_REMOVE, ($urandom_range(0, 4) != 0) ? stored_id() : pick_id(),
                        $urandom);
      end else begin
        item = make_req(cmd_t'(CMD_UNUSED), 16'($urandom), $urandom);
      end
      send_item(item);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    req          = '0;
    errors       = 0;
    burst_left   = 0;
    gaps_on      = 1'b0;
    shadow_ticks = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_table_full();
    test_random_traffic(140);

    // Drain the last transaction, then allow a full walk for any stray result.
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
